// ===== hw/rtl/tsm_pkg.sv =====
// Shared constants and controller/datapath interface types for the timestamp smoother.
package tsm_pkg;

    localparam int RING_DEPTH  = 30;
    localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int TS_W        = 64;
    localparam int DELTA_W     = 63;
    localparam int STEP_W      = 32;
    localparam int HALF_W      = STEP_W - 1;
    localparam int SUM_W       = TS_W + FILL_W;
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
    localparam int ERR_W       = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 136;

    localparam logic [SLOT_W-1:0] RING_LAST      = SLOT_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] RING_FULL      = FILL_W'(RING_DEPTH);
    localparam logic [ERR_W-1:0]  RUN_LIMIT      = ERR_W'(5);
    localparam logic [STEP_W-1:0] MIN_STEP_RESET = STEP_W'(40);

    typedef struct packed {
        logic load;
        logic eval;
        logic scan_start;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic predict;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_small;
        logic scan_done;
        logic cnt_zero;
        logic div_done;
    } t_dp_stat;

endpackage

// ===== hw/rtl/tsm_datapath.sv =====
// Datapath: timestamp state, increment ring, scan accumulator, divider and result register.
module tsm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsm_pkg::STEP_W-1:0]          i_cfg_wdata,
    input  logic                                i_ts_present,
    input  logic [tsm_pkg::TS_W-1:0]            i_ts_value,
    input  logic                                i_is_presentation,
    input  tsm_pkg::t_dp_cmd                    i_cmd,
    output tsm_pkg::t_dp_stat                   o_stat,
    output logic [tsm_pkg::OUT_TDATA_W-1:0]     o_tdata
);

    logic [tsm_pkg::STEP_W-1:0]    r_min_step;
    logic                          r_in_present;
    logic [tsm_pkg::TS_W-1:0]      r_in_value;
    logic                          r_in_pres;
    logic                          r_small;

    logic [tsm_pkg::DELTA_W-1:0]   r_ring [tsm_pkg::RING_DEPTH];
    logic [tsm_pkg::DELTA_W-1:0]   r_rd_data;
    logic                          r_rd_vld;
    logic [tsm_pkg::SLOT_W-1:0]    r_rd_addr;
    logic [tsm_pkg::FILL_W-1:0]    r_issued;

    logic [tsm_pkg::SLOT_W-1:0]    r_wr_slot;
    logic [tsm_pkg::FILL_W-1:0]    r_fill;
    logic [tsm_pkg::TS_W-1:0]      r_last_p;
    logic                          r_last_p_vld;
    logic [tsm_pkg::TS_W-1:0]      r_last_d;
    logic                          r_last_d_vld;
    logic [tsm_pkg::TS_W-1:0]      r_drift;
    logic [tsm_pkg::ERR_W-1:0]     r_err;

    logic [tsm_pkg::SUM_W-1:0]     r_sum;
    logic [tsm_pkg::FILL_W-1:0]    r_cnt;
    logic [tsm_pkg::SUM_W-1:0]     r_quo;
    logic [tsm_pkg::FILL_W-1:0]    r_rem;
    logic [tsm_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [tsm_pkg::TS_W-1:0]      r_pred;

    logic                          r_out_present;
    logic [tsm_pkg::TS_W-1:0]      r_out_value;
    logic                          r_out_corrected;
    logic                          r_out_restarted;
    logic [tsm_pkg::TS_W-1:0]      r_out_drift;

    logic [tsm_pkg::TS_W-1:0]      w_last;
    logic                          w_vld;
    logic [tsm_pkg::HALF_W-1:0]    w_half;
    logic [tsm_pkg::DELTA_W-1:0]   w_half_ext;
    logic                          w_small;
    logic                          w_rd_en;
    logic [tsm_pkg::SLOT_W-1:0]    w_rd_prev;
    logic [tsm_pkg::FILL_W:0]      w_trial;
    logic                          w_qbit;
    logic [tsm_pkg::TS_W-1:0]      w_mean;
    logic [tsm_pkg::TS_W-1:0]      w_step_ext;
    logic [tsm_pkg::TS_W-1:0]      w_inc;
    logic [tsm_pkg::TS_W-1:0]      w_delta;
    logic [tsm_pkg::DELTA_W-1:0]   w_ring_data;
    logic                          w_ring_we;
    logic [tsm_pkg::TS_W-1:0]      w_out_ts;
    logic [tsm_pkg::ERR_W-1:0]     n_err;
    logic [tsm_pkg::TS_W-1:0]      n_drift;
    logic                          w_restart;

    assign w_last     = r_in_pres ? r_last_p : r_last_d;
    assign w_vld      = r_in_pres ? r_last_p_vld : r_last_d_vld;
    assign w_half     = r_min_step[tsm_pkg::STEP_W-1:1];
    assign w_half_ext = {{(tsm_pkg::DELTA_W - tsm_pkg::HALF_W){1'b0}}, w_half};

    // Exact test: no wrap on last plus half step
    assign w_small = r_in_present && w_vld &&
        ($signed({{2{r_in_value[tsm_pkg::TS_W-1]}}, r_in_value}) <
         ($signed({{2{w_last[tsm_pkg::TS_W-1]}}, w_last}) +
          $signed({{(tsm_pkg::TS_W + 2 - tsm_pkg::HALF_W){1'b0}}, w_half})));

    assign w_rd_en   = i_cmd.scan_step && (r_issued != r_fill);
    assign w_rd_prev = (r_rd_addr == '0) ? tsm_pkg::RING_LAST : r_rd_addr - 1'b1;

    assign w_trial = {r_rem, r_quo[tsm_pkg::SUM_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_cnt});

    assign w_mean     = r_quo[tsm_pkg::TS_W-1:0];
    assign w_step_ext = {{(tsm_pkg::TS_W - tsm_pkg::STEP_W){1'b0}}, r_min_step};
    assign w_inc      = (w_mean > w_step_ext) ? w_mean : w_step_ext;

    assign w_delta     = r_in_value - w_last;
    assign w_ring_data = w_delta[tsm_pkg::TS_W-1] ? '1 : w_delta[tsm_pkg::DELTA_W-1:0];
    assign w_ring_we   = i_cmd.commit && r_in_present && !r_small && w_vld && (w_delta != '0);

    assign w_out_ts  = r_small ? r_pred : r_in_value;
    assign n_err     = r_small ? r_err + 1'b1 : '0;
    assign w_restart = r_small && (n_err > tsm_pkg::RUN_LIMIT);
    assign n_drift   = r_small ? r_drift + r_pred - r_in_value : r_drift;

    assign o_stat.is_small  = w_small;
    assign o_stat.scan_done = (r_issued == r_fill) && !r_rd_vld;
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.div_done  = (r_div_cnt == '0);

    assign o_tdata = {5'd0, r_out_drift, r_out_restarted, r_out_corrected,
                      r_out_value, r_out_present};

    // Increment ring
    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[r_wr_slot] <= w_ring_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_ring[r_rd_addr];
        end
    end

    // Captured word, scan, divider and prediction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_present <= i_ts_present;
            r_in_value   <= i_ts_value;
            r_in_pres    <= i_is_presentation;
        end
        if (i_cmd.eval) begin
            r_small <= w_small;
        end
        if (i_cmd.scan_start) begin
            r_rd_addr <= (r_wr_slot == '0) ? tsm_pkg::RING_LAST : r_wr_slot - 1'b1;
            r_issued  <= '0;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_quo     <= '0;
        end
        if (i_cmd.scan_step) begin
            if (w_rd_en) begin
                r_rd_addr <= w_rd_prev;
                r_issued  <= r_issued + 1'b1;
            end
            if (r_rd_vld && (r_rd_data > w_half_ext)) begin
                r_sum <= r_sum + {{(tsm_pkg::SUM_W - tsm_pkg::DELTA_W){1'b0}}, r_rd_data};
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.div_start) begin
            r_quo     <= r_sum;
            r_rem     <= '0;
            r_div_cnt <= tsm_pkg::DIV_CNT_W'(tsm_pkg::SUM_W);
        end
        if (i_cmd.div_step) begin
            r_rem     <= w_qbit ? w_trial[tsm_pkg::FILL_W-1:0] - r_cnt
                                : w_trial[tsm_pkg::FILL_W-1:0];
            r_quo     <= {r_quo[tsm_pkg::SUM_W-2:0], w_qbit};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_cmd.predict) begin
            r_pred <= w_last + w_inc;
        end
        if (i_cmd.commit) begin
            r_out_present   <= r_in_present;
            r_out_value     <= w_out_ts;
            r_out_corrected <= r_small;
            r_out_restarted <= w_restart;
            r_out_drift     <= w_restart ? '0 : n_drift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_rd_vld <= w_rd_en;
        end
    end

    // Smoother state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step   <= tsm_pkg::MIN_STEP_RESET;
            r_wr_slot    <= '0;
            r_fill       <= '0;
            r_last_p     <= '0;
            r_last_p_vld <= 1'b0;
            r_last_d     <= '0;
            r_last_d_vld <= 1'b0;
            r_drift      <= '0;
            r_err        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_step <= i_cfg_wdata;
            end
            if (i_cmd.commit && r_in_present) begin
                if (w_restart) begin
                    r_wr_slot    <= '0;
                    r_fill       <= '0;
                    r_drift      <= '0;
                    r_err        <= '0;
                    r_last_p     <= r_in_pres ? w_out_ts : '0;
                    r_last_p_vld <= r_in_pres;
                    r_last_d     <= r_in_pres ? '0 : w_out_ts;
                    r_last_d_vld <= !r_in_pres;
                end else begin
                    r_err   <= n_err;
                    r_drift <= n_drift;
                    if (w_ring_we) begin
                        r_wr_slot <= (r_wr_slot == tsm_pkg::RING_LAST) ? '0
                                                                     : r_wr_slot + 1'b1;
                        if (r_fill != tsm_pkg::RING_FULL) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    if (r_in_pres) begin
                        r_last_p     <= w_out_ts;
                        r_last_p_vld <= 1'b1;
                    end else begin
                        r_last_d     <= w_out_ts;
                        r_last_d_vld <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/tsm_ctrl.sv =====
// Controller: sequences accept, test, ring scan, division, prediction and result hand-off.
module tsm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    input  tsm_pkg::t_dp_stat  i_stat,
    output tsm_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PRED = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_m_valid;
    logic       w_out_free;

    assign w_out_free = !r_m_valid || i_m_ready;
    assign o_s_ready  = (r_state == ST_IDLE);
    assign o_m_valid  = r_m_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.is_small) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    if (i_stat.cnt_zero) begin
                        n_state = ST_PRED;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_PRED;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_PRED: begin
                o_cmd.predict = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/media_timestamp_smoother_unit.sv =====
// Each accepted word yields exactly one result word. An absent timestamp, a first timestamp of
// its kind or a plausible one passes through accept, test and commit before its result is registered.
// A timestamp whose increment falls below half of min_step is predicted: the increment ring is
// read newest first, one entry a cycle through its single read port; then, if any stored
// increment exceeds half of min_step, a bit-serial divider forms the mean, followed by the
// prediction and commit steps. Commit waits while downstream holds an earlier result. One word is
// worked on at a time; the next is accepted as soon as the previous result sits in the output
// register, even while downstream holds it. min_step must be written only while the block is
// idle; the block itself does not enforce this.
module media_timestamp_smoother_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsm_pkg::STEP_W-1:0]          i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [0] ts_present, [64:1] ts_value, [71:65] zero
    input  logic [tsm_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [0] is_presentation
    input  logic [0:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] out_present, [64:1] out_value, [65] was_corrected, [66] restarted,
    // [130:67] drift_total, [135:131] zero
    output logic [tsm_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    tsm_pkg::t_dp_cmd  w_cmd;
    tsm_pkg::t_dp_stat w_stat;

    tsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    tsm_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_ts_present      (i_s_axis_tdata[0]),
        .i_ts_value        (i_s_axis_tdata[tsm_pkg::TS_W:1]),
        .i_is_presentation (i_s_axis_tuser[0]),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_tdata           (o_m_axis_tdata)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the media timestamp smoother: stream stimulus and result check.
`timescale 1ns / 1ps

module tb;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [63:0] TS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TS_MIN      = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        present;
        logic [63:0] value;
        logic        corrected;
        logic        restarted;
        logic [63:0] drift;
    } t_stamp_out;

    class ts_smoother_mirror;
        logic [63:0] incr_ring [tsm_pkg::RING_DEPTH];
        int unsigned wr_slot;
        int unsigned fill;
        logic [63:0] last_val [2];
        bit          last_ok [2];
        logic [63:0] drift;
        int unsigned err_run;
        logic [31:0] min_step;
        t_stamp_out  awaited [$];
        int          faults;
        int          checked;
        int          predicted;
        int          restarts;

        function new();
            wipe();
            min_step  = tsm_pkg::MIN_STEP_RESET;
            faults    = 0;
            checked   = 0;
            predicted = 0;
            restarts  = 0;
        endfunction

        function void wipe();
            foreach (incr_ring[i]) incr_ring[i] = '0;
            wr_slot     = 0;
            fill        = 0;
            last_val[0] = '0;
            last_val[1] = '0;
            last_ok[0]  = 0;
            last_ok[1]  = 0;
            drift       = '0;
            err_run     = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void take_stamp(bit present, logic [63:0] ts, bit pres);
            t_stamp_out  e;
            int          k;
            int unsigned s;
            logic [63:0] half;
            logic [63:0] incr;
            logic [63:0] d;
            logic [63:0] q;
            logic [63:0] r;
            logic [63:0] n;
            logic [63:0] pred;
            longint      sl;
            bit          too_close;
            e = '0;
            if (present) begin
                k = pres ? 1 : 0;
                half = {32'b0, min_step} >> 1;
                too_close = 0;
                if (last_ok[k]) begin
                    sl = longint'(last_val[k]);
                    if (sl > longint'(TS_MAX - half))
                        too_close = 1;
                    else
                        too_close = longint'(ts) < sl + longint'(half);
                end
                if (too_close) begin
                    incr = {32'b0, min_step};
                    n = '0;
                    for (int i = 0; i < fill; i++) begin
                        s = (wr_slot + 2 * tsm_pkg::RING_DEPTH - 1 - i) % tsm_pkg::RING_DEPTH;
                        if (incr_ring[s] > half) n++;
                    end
                    if (n != 0) begin
                        q = '0;
                        r = '0;
                        for (int i = 0; i < fill; i++) begin
                            s = (wr_slot + 2 * tsm_pkg::RING_DEPTH - 1 - i)
                                % tsm_pkg::RING_DEPTH;
                            if (incr_ring[s] > half) begin
                                q += incr_ring[s] / n;
                                r += incr_ring[s] % n;
                            end
                        end
                        if (q + r / n > incr) incr = q + r / n;
                    end
                    pred = last_val[k] + incr;
                    drift += pred - ts;
                    ts = pred;
                    e.corrected = 1;
                    err_run++;
                    predicted++;
                end else begin
                    if (last_ok[k]) begin
                        d = ts - last_val[k];
                        if (d != 0) begin
                            if (d > TS_MAX) d = TS_MAX;
                            incr_ring[wr_slot] = d;
                            wr_slot = (wr_slot + 1) % tsm_pkg::RING_DEPTH;
                            if (fill < tsm_pkg::RING_DEPTH) fill++;
                        end
                    end
                    err_run = 0;
                end
                if (err_run > tsm_pkg::RUN_LIMIT) begin
                    wipe();
                    e.restarted = 1;
                    restarts++;
                end
                last_val[k] = ts;
                last_ok[k]  = 1;
            end
            e.present = present;
            e.value   = ts;
            e.drift   = drift;
            awaited.push_back(e);
        endfunction

        function void match_stamp(logic [tsm_pkg::OUT_TDATA_W-1:0] word);
            t_stamp_out got;
            t_stamp_out exp;
            got.present   = word[0];
            got.value     = word[64:1];
            got.corrected = word[65];
            got.restarted = word[66];
            got.drift     = word[130:67];
            if (awaited.size() == 0) begin
                $error("result word with nothing outstanding: %h", word);
                faults++;
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (got.present !== exp.present) begin
                $error("out_present: expected %0d, got %0d", exp.present, got.present);
                faults++;
            end
            if (got.value !== exp.value) begin
                $error("out_value: expected %0d, got %0d", $signed(exp.value),
                       $signed(got.value));
                faults++;
            end
            if (got.corrected !== exp.corrected) begin
                $error("was_corrected: expected %0d, got %0d", exp.corrected,
                       got.corrected);
                faults++;
            end
            if (got.restarted !== exp.restarted) begin
                $error("restarted: expected %0d, got %0d", exp.restarted, got.restarted);
                faults++;
            end
            if (got.drift !== exp.drift) begin
                $error("drift_total: expected %0d, got %0d", $signed(exp.drift),
                       $signed(got.drift));
                faults++;
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [tsm_pkg::STEP_W-1:0]      i_cfg_wdata;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [tsm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [0:0]                      i_s_axis_tuser;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [tsm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    ts_smoother_mirror board;
    int                cycles;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                hold_asks;
    int                hold_done;
    int                hold_left;
    logic [63:0]       tx_base [2];

    media_timestamp_smoother_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        cycles          = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        hold_asks       = 0;
        hold_done       = 0;
        hold_left       = 0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_asks != hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_asks;
        end
        if (hold_left > 0) begin
            i_m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready = $urandom_range(0, 99) >= rx_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) board.match_stamp(o_m_axis_tdata);
        if (cycles > CYCLE_LIMIT) begin
            $display("[media_timestamp_smoother_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] legal_ts(logic [63:0] v);
        return (v == TS_MIN) ? v + 1 : v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic present, input logic [63:0] value, input logic pres);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'b0, value, present};
        i_s_axis_tuser  = pres;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.take_stamp(present, value, pres);
        @(negedge i_clk);
    endtask

    task automatic retune_min_step(input logic [31:0] v);
        i_s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we       = 1'b0;
        board.min_step = v;
    endtask

    task automatic stream_phase(input int count);
        int          glitch_left;
        int          r;
        bit          kind;
        logic [63:0] unit;
        logic [63:0] step;
        logic [63:0] v;
        glitch_left = 0;
        kind        = 0;
        tx_base[0]  = legal_ts({$urandom, $urandom});
        tx_base[1]  = {32'b0, $urandom};
        for (int i = 0; i < count; i++) begin
            r    = $urandom_range(0, 99);
            unit = (board.min_step < 4) ? 64'd25 : {32'b0, board.min_step};
            if (glitch_left > 0) begin
                glitch_left--;
                v = legal_ts(tx_base[kind] + ($urandom % (unit / 2 + 1)));
                send_word(1'b1, v, kind);
                tx_base[kind] = v;
            end else if (r < 8) begin
                send_word(1'b0, legal_ts({$urandom, $urandom}), 1'($urandom_range(0, 1)));
            end else if (r < 13) begin
                kind = 1'($urandom_range(0, 1));
                v    = legal_ts({$urandom, $urandom});
                send_word(1'b1, v, kind);
                tx_base[kind] = v;
            end else begin
                kind = 1'($urandom_range(0, 1));
                if (r < 19) glitch_left = $urandom_range(2, 8);
                r = $urandom_range(0, 99);
                if (r < 60)
                    step = unit + ($urandom % (unit / 4 + 1));
                else if (r < 68)
                    step = '0;
                else if (r < 84)
                    step = $urandom % (unit / 2 + 1);
                else if (r < 94)
                    step = -(($urandom % (unit * 3)) + 1);
                else
                    step = {$urandom, $urandom};
                v = legal_ts(tx_base[kind] + step);
                send_word(1'b1, v, kind);
                tx_base[kind] = v;
            end
        end
    endtask

    initial begin
        logic [31:0] step_set [6];
        board = new();
        step_set = '{32'hFFFF_FFFF, 32'd0, 32'd3000, 32'd1, 32'd0, tsm_pkg::MIN_STEP_RESET};
        step_set[4] = $urandom_range(2, 200000);
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        tx_idle_pct = 12;
        rx_idle_pct = 66;

        // directed: extremes, first stamps, prediction, saturation, restart
        send_word(1'b0, TS_MAX, 1'b0);
        send_word(1'b0, legal_ts(TS_MIN), 1'b1);
        send_word(1'b1, 64'd1000, 1'b0);
        send_word(1'b1, 64'd1040, 1'b0);
        send_word(1'b1, 64'd1080, 1'b0);
        send_word(1'b1, 64'd1085, 1'b0);
        send_word(1'b1, legal_ts(TS_MIN), 1'b1);
        send_word(1'b1, TS_MAX, 1'b1);
        send_word(1'b1, TS_MAX, 1'b1);
        send_word(1'b1, 64'd1200, 1'b0);
        repeat (6) send_word(1'b1, 64'd1200, 1'b0);
        send_word(1'b1, 64'd1300, 1'b0);
        send_word(1'b1, 64'd5, 1'b1);
        send_word(1'b1, 64'd5, 1'b1);
        send_word(1'b0, 64'h5555_5555_5555_5555, 1'b0);
        send_word(1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                tx_idle_pct = 66;
                rx_idle_pct = 12;
            end
            if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            retune_min_step(step_set[p]);
            // long downstream stall while words keep coming
            if (p == 1 || p == 4) hold_asks++;
            stream_phase(108);
        end

        i_s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("%0d result words checked: %0d predicted, %0d state restarts",
                 board.checked, board.predicted, board.restarts);
        $display("min_step settings: reset value, 0, 1, 3000, %0d, 4294967295", step_set[4]);
        if (board.faults == 0)
            $display("[media_timestamp_smoother_unit] OK");
        else
            $display("[media_timestamp_smoother_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tsm_pkg.sv
hw/rtl/tsm_datapath.sv
hw/rtl/tsm_ctrl.sv
hw/rtl/media_timestamp_smoother_unit.sv
sim/tb.sv
